[hdl/weighted_sq_exp_kernel_top_assert.svh]
// Assertion macros for the weighted squared-exponential kernel.
// Included by the port checker; relies on clk and rst_n in the including scope.
`ifndef WEIGHTED_SQ_EXP_KERNEL_TOP_ASSERT_SVH
`define WEIGHTED_SQ_EXP_KERNEL_TOP_ASSERT_SVH

// Implication in the same cycle.
`define WSEK_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("weighted_sq_exp_kernel_top: check failed");

// Implication in the next cycle.
`define WSEK_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("weighted_sq_exp_kernel_top: check failed");

`endif

[hdl/wsek_pkg.sv]
// Shared widths, constants, types and tables of the weighted squared-exponential kernel.
// No dependencies.
package wsek_pkg;

  localparam int DIMS       = 4;
  localparam int MAX_DIMS   = 4;
  localparam int COORD_W    = 16;
  localparam int WEIGHT_W   = 16;
  localparam int SIGMA_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ABS_W      = 17;
  localparam int SQ_W       = 33;
  localparam int WSQ_W      = 48;
  localparam int NPAIR      = (DIMS + 1) / 2;
  localparam int PAIR_W     = WSQ_W + 1;
  localparam int DIST_W     = 50;
  localparam int X_W        = 20;
  localparam int INV_W      = 21;
  localparam int KP_W       = X_W + INV_W;
  localparam int K_W        = 5;
  localparam int FRAC_W     = 32;
  localparam int RED_W      = X_W + 16;
  localparam int ACC_W      = FRAC_W + 1;
  localparam int RND_W      = ACC_W + 1;
  localparam int SH_W       = 6;
  localparam int N_W        = 4;
  localparam int E_W        = 17;
  localparam int COV_W      = 32;
  localparam int PROD_W     = SIGMA_W + E_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int TAYLOR_TERMS = 13;
  localparam int LAT = 3 + 2 + 4 + 3 * (TAYLOR_TERMS - 1) + 2;

  localparam logic [FRAC_W-1:0] LN2_Q32    = 32'hB17217F8;
  localparam logic [INV_W-1:0]  INV_LN2    = 21'd1512775;
  localparam int                INV_SHIFT  = 36;
  localparam logic [DIST_W-1:0] LIMIT_Q28  = DIST_W'(12) << 28;
  localparam logic [ACC_W-1:0]  ONE_Q32    = ACC_W'(1) << FRAC_W;
  localparam logic [COV_W-1:0]  NUGGET_Q24 = 32'd16777;
  localparam logic [SIGMA_W-1:0]  SIGMA_RST  = 16'd256;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 16'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIGMA   = 3'd0,
    CFG_WEIGHT0 = 3'd1,
    CFG_WEIGHT1 = 3'd2,
    CFG_WEIGHT2 = 3'd3,
    CFG_WEIGHT3 = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [FRAC_W-1:0] r;
    logic [K_W-1:0]    k;
    logic              big;
    logic              zero;
  } side_t;

  // floor(2^32 / n) for the Taylor term divisors.
  function automatic logic [FRAC_W-1:0] recip_q32(input logic [N_W-1:0] n);
    logic [FRAC_W-1:0] v;
    unique case (n)
      4'd2:    v = 32'd2147483648;
      4'd3:    v = 32'd1431655765;
      4'd4:    v = 32'd1073741824;
      4'd5:    v = 32'd858993459;
      4'd6:    v = 32'd715827882;
      4'd7:    v = 32'd613566756;
      4'd8:    v = 32'd536870912;
      4'd9:    v = 32'd477218588;
      4'd10:   v = 32'd429496729;
      4'd11:   v = 32'd390451572;
      4'd12:   v = 32'd357913941;
      4'd13:   v = 32'd330382099;
      default: v = 32'hFFFFFFFF;
    endcase
    return v;
  endfunction

endpackage

[hdl/wsek_lane.sv]
// One dimension lane: difference, square and weighting of one coordinate pair.
// Depends on wsek_pkg.
module wsek_lane (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [wsek_pkg::COORD_W-1:0] a_i,
  input  logic signed [wsek_pkg::COORD_W-1:0] b_i,
  input  logic [wsek_pkg::WEIGHT_W-1:0]  weight_i,
  output logic [wsek_pkg::WSQ_W-1:0]     wsq_o
);
  import wsek_pkg::*;

  logic signed [ABS_W-1:0]    diff;
  logic [ABS_W-1:0]           ad_nxt;
  logic [ABS_W-1:0]           ad_r;
  logic [2*ABS_W-1:0]         sq_full;
  logic [SQ_W-1:0]            sq_r;
  logic [SQ_W+WEIGHT_W-1:0]   wsq_full;
  logic [WSQ_W-1:0]           wsq_r;

  always_comb begin
    diff     = ABS_W'(a_i) - ABS_W'(b_i);
    ad_nxt   = diff[ABS_W-1] ? ABS_W'(-diff) : ABS_W'(diff);
    sq_full  = ad_r * ad_r;
    wsq_full = sq_r * weight_i;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ad_r  <= ad_nxt;
      sq_r  <= sq_full[SQ_W-1:0];
      wsq_r <= wsq_full[WSQ_W-1:0];
    end
  end

  assign wsq_o = wsq_r;

endmodule

[hdl/wsek_merge.sv]
// Merging stage: registered adder tree over the lane results.
// Depends on wsek_pkg.
module wsek_merge (
  input  logic                          clk,
  input  logic                          en,
  input  logic [wsek_pkg::WSQ_W-1:0]    wsq_i [wsek_pkg::DIMS],
  output logic [wsek_pkg::DIST_W-1:0]   dist_o
);
  import wsek_pkg::*;

  logic [PAIR_W-1:0] pair_nxt [NPAIR];
  logic [PAIR_W-1:0] pair_r   [NPAIR];
  logic [DIST_W-1:0] dist_nxt;
  logic [DIST_W-1:0] dist_r;

  always_comb begin
    for (int j = 0; j < NPAIR; j++) begin
      if (2 * j + 1 < DIMS) begin
        pair_nxt[j] = PAIR_W'(wsq_i[2*j]) + PAIR_W'(wsq_i[2*j+1]);
      end else begin
        pair_nxt[j] = PAIR_W'(wsq_i[2*j]);
      end
    end
    dist_nxt = '0;
    for (int j = 0; j < NPAIR; j++) begin
      dist_nxt = dist_nxt + DIST_W'(pair_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pair_r <= pair_nxt;
      dist_r <= dist_nxt;
    end
  end

  assign dist_o = dist_r;

endmodule

[hdl/wsek_tstep.sv]
// One Taylor step of exp(-r): multiply by r, divide by the step index, accumulate.
// Depends on wsek_pkg; the step index and its reciprocal arrive as constants.
module wsek_tstep (
  input  logic                          clk,
  input  logic                          en,
  input  logic [wsek_pkg::N_W-1:0]      n_i,
  input  logic [wsek_pkg::FRAC_W-1:0]   recip_i,
  input  logic [wsek_pkg::FRAC_W-1:0]   term_i,
  input  logic [wsek_pkg::ACC_W-1:0]    acc_i,
  input  wsek_pkg::side_t               side_i,
  output logic [wsek_pkg::FRAC_W-1:0]   term_o,
  output logic [wsek_pkg::ACC_W-1:0]    acc_o,
  output wsek_pkg::side_t               side_o
);
  import wsek_pkg::*;

  logic [2*FRAC_W-1:0] mul_a;
  logic [ACC_W-1:0]    acc_a_nxt;
  logic [FRAC_W-1:0]   q_a_r;
  logic [ACC_W-1:0]    acc_a_r;
  side_t               side_a_r;
  logic [2*FRAC_W-1:0] mul_b;
  logic [2*FRAC_W-1:0] prod_b_r;
  logic [FRAC_W-1:0]   q_b_r;
  logic [ACC_W-1:0]    acc_b_r;
  side_t               side_b_r;
  logic [FRAC_W-1:0]   est;
  logic [FRAC_W-1:0]   rem;
  logic [FRAC_W-1:0]   term_nxt;
  logic [FRAC_W-1:0]   term_r;
  logic [ACC_W-1:0]    acc_r;
  side_t               side_r;

  always_comb begin
    mul_a = (2*FRAC_W)'(term_i) * (2*FRAC_W)'(side_i.r);
    // The incoming term belongs to step n-1; odd powers are subtracted.
    if (n_i[0]) begin
      acc_a_nxt = acc_i + ACC_W'(term_i);
    end else begin
      acc_a_nxt = acc_i - ACC_W'(term_i);
    end
    mul_b    = (2*FRAC_W)'(q_a_r) * (2*FRAC_W)'(recip_i);
    est      = prod_b_r[2*FRAC_W-1:FRAC_W];
    rem      = q_b_r - FRAC_W'(est * FRAC_W'(n_i));
    term_nxt = (rem >= FRAC_W'(n_i)) ? est + FRAC_W'(1) : est;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_a_r    <= mul_a[2*FRAC_W-1:FRAC_W];
      acc_a_r  <= acc_a_nxt;
      side_a_r <= side_i;
      prod_b_r <= mul_b;
      q_b_r    <= q_a_r;
      acc_b_r  <= acc_a_r;
      side_b_r <= side_a_r;
      term_r   <= term_nxt;
      acc_r    <= acc_b_r;
      side_r   <= side_b_r;
    end
  end

  assign term_o = term_r;
  assign acc_o  = acc_r;
  assign side_o = side_r;

endmodule

[hdl/wsek_exp.sv]
// exp(-S) unit: range reduction by ln 2, Taylor chain, rounding to Q.16.
// Depends on wsek_pkg and wsek_tstep.
module wsek_exp (
  input  logic                          clk,
  input  logic                          en,
  input  logic [wsek_pkg::DIST_W-1:0]   dist_i,
  output logic [wsek_pkg::E_W-1:0]      e_o,
  output logic                          zero_o
);
  import wsek_pkg::*;

  logic [X_W-1:0]    x1_r;
  logic              zero1_r;
  logic              big1_r;
  logic [KP_W-1:0]   kp_r;
  logic [X_W-1:0]    x2_r;
  logic              zero2_r;
  logic              big2_r;
  logic [K_W-1:0]    kest;
  logic [RED_W-1:0]  red;
  logic [ACC_W-1:0]  r0_r;
  logic [K_W-1:0]    k3_r;
  logic              zero3_r;
  logic              big3_r;
  side_t             side4_nxt;
  side_t             side4_r;
  logic [FRAC_W-1:0] term_c [TAYLOR_TERMS+1];
  logic [ACC_W-1:0]  acc_c  [TAYLOR_TERMS+1];
  side_t             side_c [TAYLOR_TERMS+1];
  logic [ACC_W-1:0]  accf_r;
  side_t             sidef_r;
  logic [SH_W-1:0]   sh;
  logic [RND_W-1:0]  rnd;
  logic [RND_W-1:0]  e_full;
  logic [E_W-1:0]    e_r;
  logic              zero_r;

  always_comb begin
    kest = kp_r[INV_SHIFT+K_W-1:INV_SHIFT];
    red  = {x2_r, 16'b0} - RED_W'(kest) * RED_W'(LN2_Q32);
    if (r0_r >= ACC_W'(LN2_Q32)) begin
      side4_nxt.r = FRAC_W'(r0_r - ACC_W'(LN2_Q32));
      side4_nxt.k = k3_r + K_W'(1);
    end else begin
      side4_nxt.r = FRAC_W'(r0_r);
      side4_nxt.k = k3_r;
    end
    side4_nxt.big  = big3_r;
    side4_nxt.zero = zero3_r;
    sh     = SH_W'(sidef_r.k) + SH_W'(16);
    rnd    = RND_W'(accf_r) + (RND_W'(1) << (sh - SH_W'(1)));
    e_full = rnd >> sh;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r    <= dist_i[X_W+11:12];
      zero1_r <= (dist_i == '0);
      big1_r  <= (dist_i >= LIMIT_Q28);
      kp_r    <= KP_W'(x1_r) * KP_W'(INV_LN2);
      x2_r    <= x1_r;
      zero2_r <= zero1_r;
      big2_r  <= big1_r;
      r0_r    <= red[ACC_W-1:0];
      k3_r    <= kest;
      zero3_r <= zero2_r;
      big3_r  <= big2_r;
      side4_r <= side4_nxt;
      accf_r  <= acc_c[TAYLOR_TERMS] - ACC_W'(term_c[TAYLOR_TERMS]);
      sidef_r <= side_c[TAYLOR_TERMS];
      e_r     <= sidef_r.big ? '0 : e_full[E_W-1:0];
      zero_r  <= sidef_r.zero;
    end
  end

  assign term_c[1] = side4_r.r;
  assign acc_c[1]  = ONE_Q32;
  assign side_c[1] = side4_r;
  assign term_c[0] = '0;
  assign acc_c[0]  = '0;
  assign side_c[0] = '0;

  for (genvar n = 2; n <= TAYLOR_TERMS; n++) begin : g_step
    wsek_tstep u_step (
      .clk     (clk),
      .en      (en),
      .n_i     (N_W'(n)),
      .recip_i (recip_q32(N_W'(n))),
      .term_i  (term_c[n-1]),
      .acc_i   (acc_c[n-1]),
      .side_i  (side_c[n-1]),
      .term_o  (term_c[n]),
      .acc_o   (acc_c[n]),
      .side_o  (side_c[n])
    );
  end

  assign e_o    = e_r;
  assign zero_o = zero_r;

endmodule

[hdl/weighted_sq_exp_kernel_top.sv]
// Top level of the weighted squared-exponential covariance kernel.
// Depends on wsek_pkg, wsek_lane, wsek_merge and wsek_exp.
//
// Takes one point pair per clock cycle while in_stall is low and passes its
// covariance through registers in order: the dimension lanes, the adder tree,
// reduction by ln 2, the chain of twelve Taylor steps of three stages each,
// the final term and rounding, and the scale by sigma_squared in the output
// register. The whole pipeline moves as one; while an output beat is held by
// out_stall, in_stall is high. Configuration registers are read live, so write
// them only while no beat is in flight.
module weighted_sq_exp_kernel_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [wsek_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wsek_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [wsek_pkg::COORD_W-1:0] in_first_pos0,
  input  logic signed [wsek_pkg::COORD_W-1:0] in_first_pos1,
  input  logic signed [wsek_pkg::COORD_W-1:0] in_first_pos2,
  input  logic signed [wsek_pkg::COORD_W-1:0] in_first_pos3,
  input  logic signed [wsek_pkg::COORD_W-1:0] in_second_pos0,
  input  logic signed [wsek_pkg::COORD_W-1:0] in_second_pos1,
  input  logic signed [wsek_pkg::COORD_W-1:0] in_second_pos2,
  input  logic signed [wsek_pkg::COORD_W-1:0] in_second_pos3,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [wsek_pkg::COV_W-1:0]          out_covariance,
  output logic                                out_zero_distance
);
  import wsek_pkg::*;

  logic [SIGMA_W-1:0]  sigma_r;
  logic [WEIGHT_W-1:0] weight_r [MAX_DIMS];
  logic signed [COORD_W-1:0] first_a  [MAX_DIMS];
  logic signed [COORD_W-1:0] second_a [MAX_DIMS];
  logic [WSQ_W-1:0]    wsq    [DIMS];
  logic [DIST_W-1:0]   wdist;
  logic [E_W-1:0]      e_val;
  logic                zero_val;
  logic                adv;
  logic [LAT-1:0]      vld_r;
  logic                out_valid_r;
  logic [PROD_W-1:0]   prod;
  logic [SUM_W-1:0]    sum;
  logic [COV_W-1:0]    cov_nxt;
  logic [COV_W-1:0]    cov_r;
  logic                zero_r;

  assign first_a[0]  = in_first_pos0;
  assign first_a[1]  = in_first_pos1;
  assign first_a[2]  = in_first_pos2;
  assign first_a[3]  = in_first_pos3;
  assign second_a[0] = in_second_pos0;
  assign second_a[1] = in_second_pos1;
  assign second_a[2] = in_second_pos2;
  assign second_a[3] = in_second_pos3;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_r <= SIGMA_RST;
      for (int i = 0; i < MAX_DIMS; i++) begin
        weight_r[i] <= WEIGHT_RST;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SIGMA:   sigma_r     <= cfg_wdata;
        CFG_WEIGHT0: weight_r[0] <= cfg_wdata;
        CFG_WEIGHT1: weight_r[1] <= cfg_wdata;
        CFG_WEIGHT2: weight_r[2] <= cfg_wdata;
        CFG_WEIGHT3: weight_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < DIMS; i++) begin : g_lane
    wsek_lane u_lane (
      .clk      (clk),
      .en       (adv),
      .a_i      (first_a[i]),
      .b_i      (second_a[i]),
      .weight_i (weight_r[i]),
      .wsq_o    (wsq[i])
    );
  end

  wsek_merge u_merge (
    .clk    (clk),
    .en     (adv),
    .wsq_i  (wsq),
    .dist_o (wdist)
  );

  wsek_exp u_exp (
    .clk    (clk),
    .en     (adv),
    .dist_i (wdist),
    .e_o    (e_val),
    .zero_o (zero_val)
  );

  always_comb begin
    prod = sigma_r * e_val;
    sum  = SUM_W'(prod) + (zero_val ? SUM_W'(NUGGET_Q24) : SUM_W'(0));
    if (sum > SUM_W'({COV_W{1'b1}})) begin
      cov_nxt = {COV_W{1'b1}};
    end else begin
      cov_nxt = sum[COV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[LAT-2:0], in_valid};
      out_valid_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cov_r  <= cov_nxt;
      zero_r <= zero_val;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_covariance    = cov_r;
  assign out_zero_distance = zero_r;

endmodule

[hdl/wsek_checker.sv]
// Port-level checks of the weighted squared-exponential kernel, bound to the top level.
// Depends on wsek_pkg and weighted_sq_exp_kernel_top_assert.svh.
`include "weighted_sq_exp_kernel_top_assert.svh"

module wsek_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [wsek_pkg::COV_W-1:0]  out_covariance,
  input logic                        out_zero_distance
);
  import wsek_pkg::*;

  `WSEK_ASSERT_IMP(a_stall_only_when_held, in_stall, out_valid && out_stall)
  `WSEK_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_covariance) && $stable(out_zero_distance))
  `WSEK_ASSERT_IMP(a_nugget_floor, out_valid && out_zero_distance, out_covariance >= NUGGET_Q24)
  `WSEK_ASSERT_IMP(a_scale_bound, out_valid && !out_zero_distance, out_covariance <= 32'hFFFF0000)

endmodule

bind weighted_sq_exp_kernel_top wsek_checker u_wsek_checker (.*);
